### rtl/e2rm_pkg.sv
`default_nettype none

package e2rm_pkg;

   localparam int ANGLE_W         = 16;
   localparam int COEF_W          = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int COEF_FRAC_BITS  = 14;

   // sine and cosine are carried at 30 fractional bits
   localparam int TRIG_FRAC_BITS  = 30;
   localparam int TRIG_W          = 32;
   localparam int PROD_W          = 2 * TRIG_W;

   localparam int CORDIC_ITERS    = 30;
   localparam int CORDIC_W        = 33;
   localparam int WRAP_W          = 36;

   // wrap, fold, one stage per micro-rotation, sign restore
   localparam int CORDIC_LATENCY  = CORDIC_ITERS + 3;
   localparam int MATRIX_LATENCY  = 6;
   localparam int LATENCY         = CORDIC_LATENCY + MATRIX_LATENCY;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [WRAP_W-1:0]   PI_Q30      = 36'sd3373259426;
   localparam logic signed [WRAP_W-1:0]   TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [WRAP_W-1:0]   HALF_PI_Q30 = 36'sd1686629713;

   localparam logic signed [CORDIC_W-1:0] ATAN_TABLE [CORDIC_ITERS] = '{
      33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159, 33'sd67021687,
      33'sd33543516,  33'sd16775851,  33'sd8388437,   33'sd4194283,   33'sd2097149,
      33'sd1048576,   33'sd524288,    33'sd262144,    33'sd131072,    33'sd65536,
      33'sd32768,     33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
      33'sd1024,      33'sd512,       33'sd256,       33'sd128,       33'sd64,
      33'sd32,        33'sd16,        33'sd8,         33'sd4,         33'sd2
   };

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] m00;
      logic signed [COEF_W-1:0] m01;
      logic signed [COEF_W-1:0] m02;
      logic signed [COEF_W-1:0] m10;
      logic signed [COEF_W-1:0] m11;
      logic signed [COEF_W-1:0] m12;
      logic signed [COEF_W-1:0] m20;
      logic signed [COEF_W-1:0] m21;
      logic signed [COEF_W-1:0] m22;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/e2rm_cordic.sv
`default_nettype none

module e2rm_cordic (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [e2rm_pkg::ANGLE_W-1:0] angle,
   output logic signed [e2rm_pkg::TRIG_W-1:0]  sin_out,
   output logic signed [e2rm_pkg::TRIG_W-1:0]  cos_out
);
   import e2rm_pkg::*;

   localparam int SHIFT = TRIG_FRAC_BITS - ANGLE_FRAC_BITS;
   localparam int EXT   = WRAP_W - ANGLE_W - SHIFT;

   logic signed [WRAP_W-1:0]   wide_angle;
   logic signed [WRAP_W-1:0]   wrap_in, wrap_ff;
   logic signed [WRAP_W-1:0]   fold_wide;
   logic                       fold_neg;

   logic signed [CORDIC_W-1:0] x_in [CORDIC_ITERS+1];
   logic signed [CORDIC_W-1:0] y_in [CORDIC_ITERS+1];
   logic signed [CORDIC_W-1:0] r_in [CORDIC_ITERS+1];
   logic                       neg_in [CORDIC_ITERS+1];
   logic signed [CORDIC_W-1:0] x_ff [CORDIC_ITERS+1];
   logic signed [CORDIC_W-1:0] y_ff [CORDIC_ITERS+1];
   logic signed [CORDIC_W-1:0] r_ff [CORDIC_ITERS+1];
   logic                       neg_ff [CORDIC_ITERS+1];

   logic signed [TRIG_W-1:0]   sin_in, sin_ff, cos_in, cos_ff;

   assign wide_angle = {{EXT{angle[ANGLE_W-1]}}, angle, {SHIFT{1'b0}}};

   // bring the angle into minus pi to pi
   always_comb begin
      if (wide_angle > PI_Q30) begin
         wrap_in = wide_angle - TWO_PI_Q30;
      end else if (wide_angle < -PI_Q30) begin
         wrap_in = wide_angle + TWO_PI_Q30;
      end else begin
         wrap_in = wide_angle;
      end
   end

   // fold into the right half plane, sign restored at the end
   always_comb begin
      if (wrap_ff > HALF_PI_Q30) begin
         fold_wide = wrap_ff - PI_Q30;
         fold_neg  = 1'b1;
      end else if (wrap_ff < -HALF_PI_Q30) begin
         fold_wide = wrap_ff + PI_Q30;
         fold_neg  = 1'b1;
      end else begin
         fold_wide = wrap_ff;
         fold_neg  = 1'b0;
      end
   end

   assign x_in[0]   = CORDIC_GAIN;
   assign y_in[0]   = '0;
   assign r_in[0]   = fold_wide[CORDIC_W-1:0];
   assign neg_in[0] = fold_neg;

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
      logic rot_pos;
      assign rot_pos       = !r_ff[i][CORDIC_W-1];
      assign x_in[i+1]     = rot_pos ? x_ff[i] - (y_ff[i] >>> i) : x_ff[i] + (y_ff[i] >>> i);
      assign y_in[i+1]     = rot_pos ? y_ff[i] + (x_ff[i] >>> i) : y_ff[i] - (x_ff[i] >>> i);
      assign r_in[i+1]     = rot_pos ? r_ff[i] - ATAN_TABLE[i] : r_ff[i] + ATAN_TABLE[i];
      assign neg_in[i+1]   = neg_ff[i];
   end

   assign sin_in = TRIG_W'(neg_ff[CORDIC_ITERS] ? -y_ff[CORDIC_ITERS] : y_ff[CORDIC_ITERS]);
   assign cos_in = TRIG_W'(neg_ff[CORDIC_ITERS] ? -x_ff[CORDIC_ITERS] : x_ff[CORDIC_ITERS]);

   always_ff @(posedge clock) begin
      if (advance) begin
         wrap_ff <= wrap_in;
         for (int k = 0; k <= CORDIC_ITERS; k++) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            r_ff[k]   <= r_in[k];
            neg_ff[k] <= neg_in[k];
         end
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

`default_nettype wire

### rtl/euler_to_rotation_matrix.sv
// throughput: one transaction per cycle while no result is held at a stalled output;
// the three cordic pipelines, with 30 micro-rotation stages each, and the multiplier
// stages all advance together and all hold together under a stall
// reset: synchronous, clears the valid pipeline only; data stages are not reset
`default_nettype none

module euler_to_rotation_matrix #(
   parameter int COEF_FRAC_BITS = e2rm_pkg::COEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  e2rm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output e2rm_pkg::rsp_type rsp_data
);
   import e2rm_pkg::*;

   localparam int ENTRIES = 9;
   localparam int Q_FRAC  = 2 * TRIG_FRAC_BITS;
   localparam int RND_SH  = Q_FRAC - COEF_FRAC_BITS;
   localparam int RND_W   = COEF_FRAC_BITS + 3;
   localparam longint SAT_HI = (COEF_FRAC_BITS >= COEF_W - 1) ?
                               (longint'(1) <<< (COEF_W - 1)) - 1 :
                               longint'(1) <<< COEF_FRAC_BITS;
   localparam longint SAT_LO = (COEF_FRAC_BITS >= COEF_W - 1) ?
                               -(longint'(1) <<< (COEF_W - 1)) :
                               -(longint'(1) <<< COEF_FRAC_BITS);
   localparam logic signed [RND_W-1:0]  SAT_HI_V  = RND_W'(SAT_HI);
   localparam logic signed [RND_W-1:0]  SAT_LO_V  = RND_W'(SAT_LO);
   localparam logic signed [PROD_W-1:0] HALF_TRIG = PROD_W'(longint'(1) <<< (TRIG_FRAC_BITS - 1));
   localparam logic signed [PROD_W-1:0] HALF_COEF = PROD_W'(longint'(1) <<< (RND_SH - 1));

   typedef struct packed {
      logic signed [TRIG_W-1:0] sx;
      logic signed [TRIG_W-1:0] cx;
      logic signed [TRIG_W-1:0] sy;
      logic signed [TRIG_W-1:0] cy;
      logic signed [TRIG_W-1:0] sz;
      logic signed [TRIG_W-1:0] cz;
   } trig_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] czsysx;
      logic signed [PROD_W-1:0] czsycx;
      logic signed [PROD_W-1:0] szsysx;
      logic signed [PROD_W-1:0] szsycx;
      logic signed [PROD_W-1:0] cycz;
      logic signed [PROD_W-1:0] szcy;
      logic signed [PROD_W-1:0] cysx;
      logic signed [PROD_W-1:0] cycx;
      logic signed [PROD_W-1:0] szcx;
      logic signed [PROD_W-1:0] szsx;
      logic signed [PROD_W-1:0] czcx;
      logic signed [PROD_W-1:0] czsx;
      logic signed [TRIG_W-1:0] sy;
   } prod_type;

   logic                     advance;
   logic [LATENCY-1:0]       vld_in, vld_ff;

   logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;
   trig_type                 trig1_in, trig1_ff, trig2_ff;

   logic signed [PROD_W-1:0] czsy_in, czsy_ff, szsy_in, szsy_ff;
   logic signed [TRIG_W-1:0] rczsy_in, rczsy_ff, rszsy_in, rszsy_ff;

   prod_type                 prod_in, prod_ff;

   logic signed [PROD_W-1:0] q_in [ENTRIES];
   logic signed [PROD_W-1:0] q_ff [ENTRIES];
   logic signed [RND_W-1:0]  v_in [ENTRIES];
   logic signed [RND_W-1:0]  v_ff [ENTRIES];
   logic signed [COEF_W-1:0] sat [ENTRIES];

   rsp_type                  rsp_in, rsp_ff;

   // the whole pipeline moves unless a finished result is held at the output
   assign advance   = !(vld_ff[LATENCY-1] && rsp_stall);
   assign req_stall = !advance;
   assign vld_in    = {vld_ff[LATENCY-2:0], req_valid};

   e2rm_cordic u_cordic_roll (
      .clock   (clock),
      .advance (advance),
      .angle   (req_data.roll_angle),
      .sin_out (sx),
      .cos_out (cx)
   );

   e2rm_cordic u_cordic_pitch (
      .clock   (clock),
      .advance (advance),
      .angle   (req_data.pitch_angle),
      .sin_out (sy),
      .cos_out (cy)
   );

   e2rm_cordic u_cordic_yaw (
      .clock   (clock),
      .advance (advance),
      .angle   (req_data.yaw_angle),
      .sin_out (sz),
      .cos_out (cz)
   );

   // first pair of the three-factor terms
   assign czsy_in  = PROD_W'(cz) * PROD_W'(sy);
   assign szsy_in  = PROD_W'(sz) * PROD_W'(sy);
   assign trig1_in = '{sx: sx, cx: cx, sy: sy, cy: cy, sz: sz, cz: cz};

   // back to 30 fractional bits, round half up
   assign rczsy_in = TRIG_W'((czsy_ff + HALF_TRIG) >>> TRIG_FRAC_BITS);
   assign rszsy_in = TRIG_W'((szsy_ff + HALF_TRIG) >>> TRIG_FRAC_BITS);

   always_comb begin
      prod_in.czsysx = PROD_W'(rczsy_ff) * PROD_W'(trig2_ff.sx);
      prod_in.czsycx = PROD_W'(rczsy_ff) * PROD_W'(trig2_ff.cx);
      prod_in.szsysx = PROD_W'(rszsy_ff) * PROD_W'(trig2_ff.sx);
      prod_in.szsycx = PROD_W'(rszsy_ff) * PROD_W'(trig2_ff.cx);
      prod_in.cycz   = PROD_W'(trig2_ff.cy) * PROD_W'(trig2_ff.cz);
      prod_in.szcy   = PROD_W'(trig2_ff.sz) * PROD_W'(trig2_ff.cy);
      prod_in.cysx   = PROD_W'(trig2_ff.cy) * PROD_W'(trig2_ff.sx);
      prod_in.cycx   = PROD_W'(trig2_ff.cy) * PROD_W'(trig2_ff.cx);
      prod_in.szcx   = PROD_W'(trig2_ff.sz) * PROD_W'(trig2_ff.cx);
      prod_in.szsx   = PROD_W'(trig2_ff.sz) * PROD_W'(trig2_ff.sx);
      prod_in.czcx   = PROD_W'(trig2_ff.cz) * PROD_W'(trig2_ff.cx);
      prod_in.czsx   = PROD_W'(trig2_ff.cz) * PROD_W'(trig2_ff.sx);
      prod_in.sy     = trig2_ff.sy;
   end

   // matrix entries at 60 fractional bits
   always_comb begin
      q_in[0] = prod_ff.cycz;
      q_in[1] = prod_ff.czsysx - prod_ff.szcx;
      q_in[2] = prod_ff.czsycx + prod_ff.szsx;
      q_in[3] = prod_ff.szcy;
      q_in[4] = prod_ff.szsysx + prod_ff.czcx;
      q_in[5] = prod_ff.szsycx - prod_ff.czsx;
      q_in[6] = -(PROD_W'(prod_ff.sy) <<< TRIG_FRAC_BITS);
      q_in[7] = prod_ff.cysx;
      q_in[8] = prod_ff.cycx;
   end

   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         v_in[k] = RND_W'((q_ff[k] + HALF_COEF) >>> RND_SH);
      end
   end

   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         if (v_ff[k] > SAT_HI_V) begin
            sat[k] = COEF_W'(SAT_HI_V);
         end else if (v_ff[k] < SAT_LO_V) begin
            sat[k] = COEF_W'(SAT_LO_V);
         end else begin
            sat[k] = COEF_W'(v_ff[k]);
         end
      end
   end

   always_comb begin
      rsp_in.m00 = sat[0];
      rsp_in.m01 = sat[1];
      rsp_in.m02 = sat[2];
      rsp_in.m10 = sat[3];
      rsp_in.m11 = sat[4];
      rsp_in.m12 = sat[5];
      rsp_in.m20 = sat[6];
      rsp_in.m21 = sat[7];
      rsp_in.m22 = sat[8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trig1_ff <= trig1_in;
         czsy_ff  <= czsy_in;
         szsy_ff  <= szsy_in;
         trig2_ff <= trig1_ff;
         rczsy_ff <= rczsy_in;
         rszsy_ff <= rszsy_in;
         prod_ff  <= prod_in;
         for (int k = 0; k < ENTRIES; k++) begin
            q_ff[k] <= q_in[k];
            v_ff[k] <= v_in[k];
         end
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[LATENCY-1];
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/e2rm_checker.sv
`default_nettype none

module e2rm_checker #(
   parameter int COEF_FRAC_BITS = e2rm_pkg::COEF_FRAC_BITS
) (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input e2rm_pkg::rsp_type rsp_data
);
   import e2rm_pkg::*;

   localparam int COEF_CAP = (COEF_FRAC_BITS >= COEF_W - 1) ?
                             (2 ** (COEF_W - 1)) - 1 : 2 ** COEF_FRAC_BITS;

   // a held result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // the input side is held back exactly when a finished result waits
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output back-pressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // cosine products and the pitch sine never exceed one in magnitude
   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_data.m00) <= COEF_CAP) && (int'(rsp_data.m00) >= -COEF_CAP - 1) &&
                    (int'(rsp_data.m22) <= COEF_CAP) && (int'(rsp_data.m22) >= -COEF_CAP - 1) &&
                    (int'(rsp_data.m20) <= COEF_CAP) && (int'(rsp_data.m20) >= -COEF_CAP - 1))
      else $error("matrix entry beyond unit range");

endmodule

bind euler_to_rotation_matrix e2rm_checker #(
   .COEF_FRAC_BITS (COEF_FRAC_BITS)
) u_e2rm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### verif/rotation_checker.sv
module rotation_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  e2rm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  e2rm_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                outstanding,
   output int                matrices_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import e2rm_pkg::*;

   localparam int     ARCTAN_STEPS = 30;
   localparam longint GAIN_FX      = 64'sd652032874;
   localparam longint PI_FX        = 64'sd3373259426;
   localparam longint TWO_PI_FX    = 64'sd6746518852;
   localparam longint HALF_PI_FX   = 64'sd1686629713;
   localparam longint ARCTAN_FX [ARCTAN_STEPS] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516,  16775851,  8388437,   4194283,   2097149,
      1048576,   524288,    262144,    131072,    65536,
      32768,     16384,     8192,      4096,      2048,
      1024,      512,       256,       128,       64,
      32,        16,        8,         4,         2
   };

   rsp_type expected_matrices [$];

   initial begin
      mismatches       = 0;
      outstanding      = 0;
      matrices_checked = 0;
   end

   // sine and cosine at 30 fractional bits, angle wrapped into minus pi to pi first
   function automatic void cordic_sin_cos(input logic signed [ANGLE_W-1:0] angle,
                                          output longint sin_fx, output longint cos_fx);
      longint resid;
      longint x;
      longint y;
      longint t;
      bit     flip;
      resid = longint'(angle) * (longint'(1) << (30 - ANGLE_FRAC_BITS));
      x     = GAIN_FX;
      y     = 0;
      flip  = 1'b0;
      resid = resid % TWO_PI_FX;
      if (resid > PI_FX) resid -= TWO_PI_FX;
      if (resid < -PI_FX) resid += TWO_PI_FX;
      if (resid > HALF_PI_FX) begin
         resid -= PI_FX;
         flip = 1'b1;
      end else if (resid < -HALF_PI_FX) begin
         resid += PI_FX;
         flip = 1'b1;
      end
      for (int i = 0; i < ARCTAN_STEPS; i++) begin
         if (resid >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            resid -= ARCTAN_FX[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            resid += ARCTAN_FX[i];
         end
         x = t;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      sin_fx = y;
      cos_fx = x;
   endfunction

   // first pair rounded back to 30 fraction bits, third factor brings it to 60
   function automatic longint triple_product(input longint a, input longint b, input longint c);
      return ((a * b + (longint'(1) << 29)) >>> 30) * c;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_of(input longint q60);
      longint v;
      longint one;
      v   = (q60 + (longint'(1) << (59 - COEF_FRAC_BITS))) >>> (60 - COEF_FRAC_BITS);
      one = longint'(1) << COEF_FRAC_BITS;
      if (v > one) v = one;
      if (v < -one) v = -one;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[COEF_W-1:0];
   endfunction

   function automatic rsp_type rotation_of(input req_type angles);
      longint  sx, cx, sy, cy, sz, cz;
      rsp_type m;
      cordic_sin_cos(angles.roll_angle,  sx, cx);
      cordic_sin_cos(angles.pitch_angle, sy, cy);
      cordic_sin_cos(angles.yaw_angle,   sz, cz);
      m.m00 = coef_of(cy * cz);
      m.m01 = coef_of(triple_product(cz, sy, sx) - sz * cx);
      m.m02 = coef_of(triple_product(cz, sy, cx) + sz * sx);
      m.m10 = coef_of(sz * cy);
      m.m11 = coef_of(triple_product(sz, sy, sx) + cz * cx);
      m.m12 = coef_of(triple_product(sz, sy, cx) - cz * sx);
      m.m20 = coef_of(-sy * (longint'(1) << 30));
      m.m21 = coef_of(cy * sx);
      m.m22 = coef_of(cy * cx);
      return m;
   endfunction

   task automatic note_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_entry(input string name, input logic signed [COEF_W-1:0] got,
                                input logic signed [COEF_W-1:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s got %0d expected %0d (matrix %0d)",
                                 name, got, want, matrices_checked));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_matrices.push_back(rotation_of(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_matrices.size() == 0) begin
               note_mismatch("result transaction with nothing outstanding");
            end else begin
               want = expected_matrices.pop_front();
               compare_entry("m00", rsp_data.m00, want.m00);
               compare_entry("m01", rsp_data.m01, want.m01);
               compare_entry("m02", rsp_data.m02, want.m02);
               compare_entry("m10", rsp_data.m10, want.m10);
               compare_entry("m11", rsp_data.m11, want.m11);
               compare_entry("m12", rsp_data.m12, want.m12);
               compare_entry("m20", rsp_data.m20, want.m20);
               compare_entry("m21", rsp_data.m21, want.m21);
               compare_entry("m22", rsp_data.m22, want.m22);
               matrices_checked++;
            end
         end
         outstanding = expected_matrices.size();
      end
   end

endmodule

### verif/euler_to_rotation_matrix_tb.sv
module euler_to_rotation_matrix_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import e2rm_pkg::*;

   localparam int TRIPLE_COUNT    = 1900;
   localparam int QUIET_FROM      = 1700;
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 300;

   localparam logic signed [ANGLE_W-1:0] CORNER_ANGLES [12] = '{
      16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868, 16'sd32767,
      -16'sd32768, 16'sd1, -16'sd1, 16'sd25737, 16'sd12869, 16'sd6434
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int matrices_checked;
   int sent_count   = 0;
   bit quiet_tail   = 1'b0;
   bit backlog_done = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   euler_to_rotation_matrix DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rotation_checker matrix_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .matrices_checked (matrices_checked)
   );

   // mostly in range, some near the corners, some anywhere in the 16-bit space
   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 65535);
         1: v = int'(CORNER_ANGLES[$urandom_range(0, 11)]) + int'($urandom_range(0, 6)) - 3;
         default: v = int'($urandom_range(0, 51472)) - 25736;
      endcase
      return v[ANGLE_W-1:0];
   endfunction

   function automatic int pick_idle_odds();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 3;
         default: return 12;
      endcase
   endfunction

   task automatic send_angles(input req_type angles);
      req_valid <= 1'b1;
      req_data  <= angles;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   initial begin
      #3_000_000;
      $display("timeout with %0d matrices still outstanding", outstanding);
      $display("end of test: mismatches");
      $finish;
   end

   // result side: random stall bursts, plus one long hold-off to back up the pipeline
   initial begin
      int idle_odds;
      int cycles_in_mode;
      idle_odds      = pick_idle_odds();
      cycles_in_mode = 0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (++cycles_in_mode > 80) begin
            cycles_in_mode = 0;
            idle_odds      = pick_idle_odds();
         end
         if (!backlog_done && sent_count >= HOLD_OFF_AT) begin
            backlog_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet_tail && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   initial begin
      req_type angles;
      int      idle_odds;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners and wrapped angles, each field seeing each corner
      for (int i = 0; i < 12; i++) begin
         angles.roll_angle  = CORNER_ANGLES[i];
         angles.pitch_angle = CORNER_ANGLES[(i + 4) % 12];
         angles.yaw_angle   = CORNER_ANGLES[(i + 8) % 12];
         send_angles(angles);
      end
      foreach (CORNER_ANGLES[i]) begin
         if (i < 7 && i != 1 && i != 4) begin
            angles = '{CORNER_ANGLES[i], CORNER_ANGLES[i], CORNER_ANGLES[i]};
            send_angles(angles);
         end
      end

      idle_odds = pick_idle_odds();
      for (int n = 0; n < TRIPLE_COUNT; n++) begin
         if (n % 64 == 0) idle_odds = pick_idle_odds();
         if (n == QUIET_FROM) quiet_tail = 1'b1;
         if (!quiet_tail && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         angles.roll_angle  = pick_angle();
         angles.pitch_angle = pick_angle();
         angles.yaw_angle   = pick_angle();
         send_angles(angles);
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      $display("%0d angle triples sent, %0d rotation matrices compared entry by entry",
               sent_count, matrices_checked);
      $display("covered corner and out-of-range angles, random stalls and a %0d-cycle backlog",
               HOLD_OFF_CYCLES);
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
